// ===== rtl/sample_fifo_pwm_envelope_defines.svh =====
// ----------------------------------------------------------------------------
// sample_fifo_pwm_envelope_defines.svh
// Assertion macros for the checker file of the duty envelope block.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_FIFO_PWM_ENVELOPE_DEFINES_SVH
`define SAMPLE_FIFO_PWM_ENVELOPE_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SFPE_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sample_fifo_pwm_envelope: assertion failed");

// Clocked assertion that also holds during reset.
`define SFPE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sample_fifo_pwm_envelope: assertion failed");

`endif

// ===== rtl/sfpe_pkg.sv =====
// ----------------------------------------------------------------------------
// sfpe_pkg
// Types and constants shared by the sample FIFO and duty envelope modules.
// ----------------------------------------------------------------------------
package sfpe_pkg;

    localparam int SAMPLE_W = 16;
    localparam int INTERP_W = 15;
    localparam int INTERP_MAX = 32767;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_HI = 1'b1;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam int PCT_LOW  = 1;
    localparam int PCT_HIGH = 99;

    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] sample;
    } sample_beat_t;

endpackage

// ===== rtl/sfpe_ram.sv =====
// ----------------------------------------------------------------------------
// sfpe_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module sfpe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sfpe_fifo.sv =====
// ----------------------------------------------------------------------------
// sfpe_fifo
// Ring buffer of samples with pop-or-hold selection for each tick item.
// ----------------------------------------------------------------------------
module sfpe_fifo #(
    parameter int DEPTH = 512
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         push_acc,
    input  logic                         tick_acc,
    input  logic [sfpe_pkg::SAMPLE_W-1:0] sample_in,
    output sfpe_pkg::sample_beat_t       beat
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [PTR_W-1:0]              wr_ptr_reg;
    logic [PTR_W-1:0]              wr_ptr_next;
    logic [PTR_W-1:0]              rd_ptr_reg;
    logic [PTR_W-1:0]              rd_ptr_next;
    logic [PTR_W-1:0]              wr_ptr_inc;
    logic [PTR_W-1:0]              rd_ptr_inc;
    logic                          full;
    logic                          empty;
    logic                          wr_en;
    logic                          rd_en;
    logic [sfpe_pkg::SAMPLE_W-1:0] rd_data;
    logic [sfpe_pkg::SAMPLE_W-1:0] held_reg;
    logic [sfpe_pkg::SAMPLE_W-1:0] held_next;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic                          s1_pop_reg;
    logic                          s1_pop_next;

    assign wr_ptr_inc = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_inc = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
    assign full  = (wr_ptr_inc == rd_ptr_reg);
    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign wr_en = push_acc && !full;
    assign rd_en = tick_acc && !empty;

    assign wr_ptr_next = wr_en ? wr_ptr_inc : wr_ptr_reg;
    assign rd_ptr_next = rd_en ? rd_ptr_inc : rd_ptr_reg;

    sfpe_ram #(
        .WIDTH (sfpe_pkg::SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (sample_in),
        .rd_en   (rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

    assign beat.valid  = s1_valid_reg;
    assign beat.sample = s1_pop_reg ? rd_data : held_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_pop_next   = s1_pop_reg;
        held_next     = held_reg;
        if (en)
        begin
            s1_valid_next = tick_acc;
            s1_pop_next   = rd_en;
            if (s1_valid_reg)
            begin
                held_next = beat.sample;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            held_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s1_pop_reg   <= 1'b0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            held_reg     <= held_next;
            s1_valid_reg <= s1_valid_next;
            s1_pop_reg   <= s1_pop_next;
        end
    end

endmodule

// ===== rtl/sfpe_duty.sv =====
// ----------------------------------------------------------------------------
// sfpe_duty
// Maps a sample linearly onto the duty range in three registered steps.
// ----------------------------------------------------------------------------
module sfpe_duty #(
    parameter int DUTY_BITS = 9
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  sfpe_pkg::sample_beat_t beat,
    input  logic [DUTY_BITS-1:0]   duty_lo,
    input  logic [DUTY_BITS-1:0]   duty_hi,
    output logic                   out_valid,
    output logic [DUTY_BITS-1:0]   duty
);

    localparam int IW  = sfpe_pkg::INTERP_W;
    localparam int P_W = IW + DUTY_BITS;
    localparam int T_W = IW + 2;
    localparam int X_W = DUTY_BITS + 1;

    logic [IW-1:0]        interp;
    logic [DUTY_BITS-1:0] span;
    logic [P_W-1:0]       prod_reg;
    logic [P_W-1:0]       prod_next;
    logic                 pa_valid_reg;
    logic [DUTY_BITS-1:0] q1;
    logic [T_W-1:0]       fold1;
    logic [1:0]           fold_hi;
    logic [IW:0]          fold2;
    logic [X_W-1:0]       quot;
    logic [DUTY_BITS-1:0] quot_reg;
    logic [DUTY_BITS-1:0] quot_next;
    logic                 pb_valid_reg;
    logic [X_W-1:0]       sum;
    logic [DUTY_BITS-1:0] duty_reg;
    logic [DUTY_BITS-1:0] duty_next;
    logic                 out_valid_reg;

    // Halve the sample and offset it into 0..32767: flip the sign bit, drop the LSB.
    assign interp    = {~beat.sample[sfpe_pkg::SAMPLE_W-1],
                        beat.sample[sfpe_pkg::SAMPLE_W-2:1]};
    assign span      = (duty_hi >= duty_lo) ? duty_hi - duty_lo : '0;
    assign prod_next = P_W'(interp) * P_W'(span);

    // Division by 2^15-1 by folding the high part back onto the low part twice.
    assign q1      = prod_reg[P_W-1:IW];
    assign fold1   = T_W'(q1) + T_W'(prod_reg[IW-1:0]);
    assign fold_hi = fold1[T_W-1:IW];
    assign fold2   = (IW + 1)'(fold1[IW-1:0]) + (IW + 1)'(fold_hi);
    assign quot    = X_W'(q1) + X_W'(fold_hi)
                   + X_W'(fold2 >= (IW + 1)'(sfpe_pkg::INTERP_MAX));
    assign quot_next = quot[DUTY_BITS-1:0];

    assign sum = X_W'(duty_lo) + X_W'(quot_reg);

    always_comb
    begin
        priority if (sum < X_W'(duty_lo))
        begin
            duty_next = duty_lo;
        end
        else if (sum > X_W'(duty_hi))
        begin
            duty_next = duty_hi;
        end
        else
        begin
            duty_next = sum[DUTY_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            quot_reg <= quot_next;
            duty_reg <= duty_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pa_valid_reg  <= 1'b0;
            pb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pa_valid_reg  <= beat.valid;
            pb_valid_reg  <= pa_valid_reg;
            out_valid_reg <= pb_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign duty      = duty_reg;

endmodule

// ===== rtl/sample_fifo_pwm_envelope.sv =====
// ----------------------------------------------------------------------------
// sample_fifo_pwm_envelope
// Audio sample FIFO that turns each tick item into a PWM duty value.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals                        Content
// s_*       in         s_tvalid s_tready s_tuser s_tdata   command, sample
// m_*       out        m_tvalid m_tready m_tdata           duty
// cfg_*     in         cfg_wr_en cfg_index cfg_data        lower limit, upper limit
//
// One item is accepted every cycle while the output register is free or taken.
// A tick item passes four register stages: the FIFO RAM read, then multiply,
// divide and clamp. Its valid flag moves through matching valid registers and raises
// m_tvalid together with the clamped duty.
// Push items write the RAM on acceptance unless the FIFO is full, and give no result.
// A stall on the output freezes the whole pipeline and drops s_tready.
// Reset clears the pointers, the held sample and all valid flags; the RAM is
// not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module sample_fifo_pwm_envelope #(
    parameter int DEPTH     = 512,
    parameter int DUTY_BITS = 9
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [0:0]                          s_tuser,   // command
    input  logic [sfpe_pkg::SAMPLE_W-1:0]       s_tdata,   // sample
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((DUTY_BITS + 7) / 8) * 8-1:0] m_tdata,  // duty
    input  logic                                cfg_wr_en,
    input  logic [sfpe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [DUTY_BITS-1:0]                cfg_data
);

    localparam int OUT_W    = ((DUTY_BITS + 7) / 8) * 8;
    localparam int DUTY_TOP = (1 << DUTY_BITS) - 1;
    localparam logic [DUTY_BITS-1:0] DUTY_LO_RST =
        DUTY_BITS'((DUTY_TOP * sfpe_pkg::PCT_LOW) / 100);
    localparam logic [DUTY_BITS-1:0] DUTY_HI_RST =
        DUTY_BITS'((DUTY_TOP * sfpe_pkg::PCT_HIGH) / 100);

    logic                   en;
    logic                   acc;
    logic                   push_acc;
    logic                   tick_acc;
    logic [DUTY_BITS-1:0]   duty_lo_reg;
    logic [DUTY_BITS-1:0]   duty_hi_reg;
    logic [DUTY_BITS-1:0]   duty;
    sfpe_pkg::sample_beat_t beat;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign acc      = s_tvalid && en;
    assign push_acc = acc && (s_tuser[0] == sfpe_pkg::CMD_PUSH);
    assign tick_acc = acc && (s_tuser[0] == sfpe_pkg::CMD_TICK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_lo_reg <= DUTY_LO_RST;
            duty_hi_reg <= DUTY_HI_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                sfpe_pkg::CFG_DUTY_LO: duty_lo_reg <= cfg_data;
                sfpe_pkg::CFG_DUTY_HI: duty_hi_reg <= cfg_data;
                default:               duty_lo_reg <= duty_lo_reg;
            endcase
        end
    end

    sfpe_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .push_acc  (push_acc),
        .tick_acc  (tick_acc),
        .sample_in (s_tdata),
        .beat      (beat)
    );

    sfpe_duty #(
        .DUTY_BITS (DUTY_BITS)
    ) u_duty (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .beat      (beat),
        .duty_lo   (duty_lo_reg),
        .duty_hi   (duty_hi_reg),
        .out_valid (m_tvalid),
        .duty      (duty)
    );

    assign m_tdata = OUT_W'(duty);

endmodule

// ===== rtl/sfpe_checker.sv =====
// ----------------------------------------------------------------------------
// sfpe_checker
// Port-level checks of the duty envelope block, bound to the top level.
// ----------------------------------------------------------------------------
`include "sample_fifo_pwm_envelope_defines.svh"

module sfpe_checker #(
    parameter int DUTY_BITS = 9
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic [0:0]                           s_tuser,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [((DUTY_BITS + 7) / 8) * 8-1:0] m_tdata
);

    logic tick_acc;

    assign tick_acc = s_tvalid && s_tready && (s_tuser[0] == sfpe_pkg::CMD_TICK);

    // A stalled result keeps its value.
    `SFPE_ASSERT_RST(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // The input side is open exactly when the output register can move.
    `SFPE_ASSERT_ALWAYS(a_ready_follows_out, clk, s_tready == (!m_tvalid || m_tready))

    // A tick with no stall on the way leads to a valid result.
    `SFPE_ASSERT_RST(a_tick_latency, clk, rst_n, tick_acc ##1 s_tready ##1 s_tready ##1 s_tready |=> m_tvalid)

    // No result is pending right after reset is released.
    `SFPE_ASSERT_ALWAYS(a_reset_empty, clk, $rose(rst_n) |-> !m_tvalid)

endmodule

bind sample_fifo_pwm_envelope sfpe_checker #(
    .DUTY_BITS (DUTY_BITS)
) u_sfpe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb_sample_fifo_pwm_envelope.sv =====
// ----------------------------------------------------------------------------
// tb_sample_fifo_pwm_envelope
// Self-checking testbench for the sample FIFO and PWM duty envelope block.
// A queue of push and tick items feeds a randomly idling stream driver. A
// local predictor keeps its own copy of the sample FIFO, the held sample and
// both duty limits, and computes the duty of every accepted tick. A monitor
// compares each duty leaving the block with the oldest predicted one. The
// limits are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_sample_fifo_pwm_envelope;

    localparam int DEPTH       = 512;
    localparam int DUTY_BITS   = 9;
    localparam int DUTY_TDATA_W = ((DUTY_BITS + 7) / 8) * 8;
    localparam int FIFO_ROOM   = DEPTH - 1;
    localparam int DRAIN_PAUSE = 10;
    localparam int LONG_HOLD   = 400;
    localparam int QUIET_LIMIT = 3000;
    localparam int SMP_W       = sfpe_pkg::SAMPLE_W;

    typedef struct packed {
        logic             cmd;
        logic [SMP_W-1:0] smp;
    } audio_item_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [0:0]                     s_tuser   = sfpe_pkg::CMD_PUSH;
    logic [SMP_W-1:0]               s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [DUTY_TDATA_W-1:0]        m_tdata;
    logic                           cfg_wr_en = 1'b0;
    logic [sfpe_pkg::CFG_IDX_W-1:0] cfg_index = sfpe_pkg::CFG_DUTY_LO;
    logic [DUTY_BITS-1:0]           cfg_data  = '0;

    audio_item_t          pending_items[$];
    logic [SMP_W-1:0]     fifo_samples[$];
    logic [DUTY_BITS-1:0] expected_duty[$];
    logic [SMP_W-1:0]     held_sample;
    logic [DUTY_BITS-1:0] duty_lo;
    logic [DUTY_BITS-1:0] duty_hi;
    audio_item_t          next_item;

    int  queued_count;
    int  accepted_count;
    int  mismatch_count;
    int  src_gap;
    int  snk_gap;
    int  hold_cnt;
    int  quiet_cycles;
    bit  idle_en;
    bit  hold_req;
    bit  hold_done;

    sample_fifo_pwm_envelope #(
        .DEPTH     (DEPTH),
        .DUTY_BITS (DUTY_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic logic [DUTY_BITS-1:0] duty_of_sample(logic [SMP_W-1:0] raw);
        int unsigned level;
        int unsigned span;
        int unsigned duty;
        level = 32'({~raw[SMP_W-1], raw[SMP_W-2:0]});
        level = level >> 1;
        span  = (duty_hi >= duty_lo) ? 32'(duty_hi) - 32'(duty_lo) : 32'd0;
        duty  = 32'(duty_lo) + (level * span) / 32'(sfpe_pkg::INTERP_MAX);
        if (duty > 32'(duty_hi))
        begin
            duty = 32'(duty_hi);
        end
        return duty[DUTY_BITS-1:0];
    endfunction

    function automatic void track_item(logic cmd, logic [SMP_W-1:0] smp);
        if (cmd == sfpe_pkg::CMD_PUSH)
        begin
            if (fifo_samples.size() < FIFO_ROOM)
            begin
                fifo_samples.push_back(smp);
            end
        end
        else
        begin
            if (fifo_samples.size() != 0)
            begin
                held_sample = fifo_samples.pop_front();
            end
            expected_duty.push_back(duty_of_sample(held_sample));
        end
    endfunction

    function automatic logic [SMP_W-1:0] pick_sample();
        logic [SMP_W-1:0] corner[4];
        corner[0] = 16'h8000;
        corner[1] = 16'h7FFF;
        corner[2] = 16'h0000;
        corner[3] = 16'hFFFF;
        if ($urandom_range(0, 7) == 0)
        begin
            return corner[$urandom_range(0, 3)];
        end
        return SMP_W'($urandom());
    endfunction

    task automatic add_item(logic cmd, logic [SMP_W-1:0] smp);
        audio_item_t it;
        it.cmd = cmd;
        it.smp = (cmd == sfpe_pkg::CMD_TICK) ? logic'($urandom()) ? smp : ~smp : smp;
        pending_items.push_back(it);
        queued_count++;
    endtask

    task automatic add_mix(int count, int tick_pct);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(1, 100) <= tick_pct)
            begin
                add_item(sfpe_pkg::CMD_TICK, SMP_W'($urandom()));
            end
            else
            begin
                add_item(sfpe_pkg::CMD_PUSH, pick_sample());
            end
        end
    endtask

    task automatic wait_idle();
        while (accepted_count != queued_count || expected_duty.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic write_limits(logic [DUTY_BITS-1:0] lo, logic [DUTY_BITS-1:0] hi);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= sfpe_pkg::CFG_DUTY_LO;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= sfpe_pkg::CFG_DUTY_HI;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        duty_lo = lo;
        duty_hi = hi;
    endtask

    task automatic write_random_limits();
        logic [DUTY_BITS-1:0] a;
        logic [DUTY_BITS-1:0] b;
        a = DUTY_BITS'($urandom());
        b = DUTY_BITS'($urandom());
        if ($urandom_range(0, 4) != 0 && a > b)
        begin
            write_limits(b, a);
        end
        else
        begin
            write_limits(a, b);
        end
    endtask

    // Stream driver: presents queued items, holds each until accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tuser  <= sfpe_pkg::CMD_PUSH;
            s_tdata  <= '0;
            src_gap  <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                track_item(s_tuser[0], s_tdata);
                accepted_count++;
            end
            if (s_tvalid && !s_tready)
            begin
            end
            else if (src_gap != 0)
            begin
                s_tvalid <= 1'b0;
                src_gap  <= src_gap - 1;
            end
            else if (idle_en && $urandom_range(0, 9) == 0)
            begin
                s_tvalid <= 1'b0;
                src_gap  <= $urandom_range(0, 15);
            end
            else if (pending_items.size() != 0)
            begin
                next_item = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_item.cmd;
                s_tdata  <= next_item.smp;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off when requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            snk_gap   <= 0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == LONG_HOLD - 1)
            begin
                hold_done <= 1'b1;
            end
        end
        else if (snk_gap != 0)
        begin
            m_tready <= 1'b0;
            snk_gap  <= snk_gap - 1;
        end
        else if (idle_en && $urandom_range(0, 9) == 0)
        begin
            m_tready <= 1'b0;
            snk_gap  <= $urandom_range(0, 15);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_duty.size() == 0)
            begin
                $error("duty: expected none, actual %0d", m_tdata);
                mismatch_count++;
            end
            else if (m_tdata !== DUTY_TDATA_W'(expected_duty[0]))
            begin
                $error("duty: expected %0d, actual %0d", expected_duty[0], m_tdata);
                mismatch_count++;
                void'(expected_duty.pop_front());
            end
            else
            begin
                void'(expected_duty.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        held_sample    = '0;
        duty_lo        = DUTY_BITS'(((2 ** DUTY_BITS - 1) * sfpe_pkg::PCT_LOW) / 100);
        duty_hi        = DUTY_BITS'(((2 ** DUTY_BITS - 1) * sfpe_pkg::PCT_HIGH) / 100);
        queued_count   = 0;
        accepted_count = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        idle_en        = 1'b1;
        hold_req       = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Ticks on an empty FIFO reuse the held sample, zero after reset.
        add_item(sfpe_pkg::CMD_TICK, 16'h0000);
        add_item(sfpe_pkg::CMD_TICK, 16'hFFFF);
        add_item(sfpe_pkg::CMD_PUSH, 16'h8000);
        add_item(sfpe_pkg::CMD_PUSH, 16'h7FFF);
        add_item(sfpe_pkg::CMD_PUSH, 16'h0000);
        add_item(sfpe_pkg::CMD_PUSH, 16'hFFFF);
        add_item(sfpe_pkg::CMD_PUSH, 16'h0001);
        add_item(sfpe_pkg::CMD_PUSH, 16'h5555);
        add_item(sfpe_pkg::CMD_PUSH, 16'hAAAA);
        for (int i = 0; i < 9; i++)
        begin
            add_item(sfpe_pkg::CMD_TICK, SMP_W'($urandom()));
        end
        add_item(sfpe_pkg::CMD_PUSH, 16'h7FFE);
        add_item(sfpe_pkg::CMD_TICK, 16'h0000);
        add_item(sfpe_pkg::CMD_TICK, 16'h0000);
        wait_idle();

        write_limits(9'd0, 9'd511);
        add_mix(200, 40);
        wait_idle();

        // Lower limit above the upper one: every tick gives the upper limit.
        write_limits(9'd511, 9'd0);
        add_mix(100, 50);
        wait_idle();

        idle_en = 1'b0;
        write_limits(9'd300, 9'd300);
        add_mix(100, 50);
        wait_idle();

        // Fill the FIFO past its capacity so that pushes get dropped.
        idle_en = 1'b1;
        write_random_limits();
        add_mix(530, 0);
        add_mix(100, 80);
        wait_idle();

        write_random_limits();
        hold_req = 1'b1;
        add_mix(200, 70);
        wait_idle();

        for (int p = 0; p < 3; p++)
        begin
            write_random_limits();
            add_mix(100, $urandom_range(20, 80));
            wait_idle();
        end

        idle_en = 1'b0;
        write_random_limits();
        add_mix(150, 50);
        wait_idle();

        if (mismatch_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sfpe_pkg.sv
rtl/sfpe_ram.sv
rtl/sfpe_fifo.sv
rtl/sfpe_duty.sv
rtl/sample_fifo_pwm_envelope.sv
rtl/sfpe_checker.sv
tb/tb_sample_fifo_pwm_envelope.sv
